// ===== hdl/mactp_pkg.sv =====
// shared constants and types for the hardware address text parser
package mactp_pkg;

	localparam int ADDR_BYTES = 6;
	localparam int ACC_W      = 8 * ADDR_BYTES;
	localparam int MAC_W      = 48;
	localparam int POS_W      = 8;
	localparam int ERR_POS_W  = 5;

	localparam logic [POS_W-1:0] PLAIN_LEN = POS_W'(ADDR_BYTES * 2);
	localparam logic [POS_W-1:0] SEP_LEN   = POS_W'(ADDR_BYTES * 3 - 1);
	localparam logic [POS_W-1:0] SEP_POS   = POS_W'(2);
	localparam logic [POS_W-1:0] POS_MAX   = '1;

	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF = 8'h66;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;
	localparam logic [7:0] HEX_TEN = 8'd10;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_LENGTH,
		ERR_FIRST_DIGIT,
		ERR_SECOND_DIGIT,
		ERR_SEPARATOR
	} err_code_t;

	typedef struct packed {
		logic                 valid;
		logic [MAC_W-1:0]     mac_address;
		err_code_t            error_code;
		logic [ERR_POS_W-1:0] error_position;
	} res_t;

endpackage

// ===== hdl/mactp_char_if.sv =====
// character word channel: valid, ready, one address text character, the text length and a last-character flag
interface mactp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic [7:0] text_length;
	logic       last_char;

	modport source (output valid, output character, output text_length, output last_char,
		input ready);
	modport sink (input valid, input character, input text_length, input last_char,
		output ready);
endinterface

// ===== hdl/mactp_result_if.sv =====
// result word channel: valid, ready and the parsed address with error report
interface mactp_result_if;
	import mactp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [MAC_W-1:0]     mac_address;
	logic [2:0]           error_code;
	logic [ERR_POS_W-1:0] error_position;

	modport source (output valid, output mac_address, output error_code,
		output error_position, input ready);
	modport sink (input valid, input mac_address, input error_code, input error_position,
		output ready);
endinterface

// ===== hdl/mac_address_text_parser_unit.sv =====
// top level of the hardware address text parser
// a last character is registered at the input, then its result at the output
// throughput: one character per cycle, set by the state update in the core;
// a result waiting in the output register does not stop further characters until
// the next last character also needs the register
// reset clears the parse state and empties the input and output registers
module mac_address_text_parser_unit (
	input  logic          clk,
	input  logic          arst_n,
	mactp_char_if.sink    chars,
	mactp_result_if.source result
);
	import mactp_pkg::*;

	res_t                 res;
	logic                 out_free;
	logic                 out_valid_q;
	logic [MAC_W-1:0]     mac_q;
	err_code_t            code_q;
	logic [ERR_POS_W-1:0] epos_q;

	assign out_free = !out_valid_q || result.ready;

	mactp_parse_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.out_free (out_free),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && out_free) begin
			mac_q  <= res.mac_address;
			code_q <= res.error_code;
			epos_q <= res.error_position;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.mac_address    = mac_q;
	assign result.error_code     = code_q;
	assign result.error_position = epos_q;

	// an error word carries a zero address
	a_err_zero_mac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && code_q != ERR_NONE |-> mac_q == '0)
		else $error("error word with nonzero address");

	// length errors and clean words report no position
	a_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (code_q == ERR_NONE || code_q == ERR_LENGTH) |-> epos_q == '0)
		else $error("position reported without a character error");

	// a character error points inside the separated form
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && code_q != ERR_NONE && code_q != ERR_LENGTH
			|-> epos_q != '0 && ERR_POS_W'(epos_q) <= ERR_POS_W'(SEP_LEN))
		else $error("character error position out of range");

	// the core never offers a word while the output register is full and stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |-> !res.valid)
		else $error("result word overran the output register");
endmodule

// ===== hdl/mactp_hex_decode.sv =====
// ascii hex digit decoder, either case
module mactp_hex_decode (
	input  logic [7:0] character,
	output logic       is_hex,
	output logic [3:0] value
);
	import mactp_pkg::*;

	always_comb begin
		is_hex = 1'b1;
		value  = '0;
		if (character inside {[CH_0:CH_9]}) begin
			value = 4'(character - CH_0);
		end else if (character inside {[CH_LA:CH_LF]}) begin
			value = 4'(character - CH_LA + HEX_TEN);
		end else if (character inside {[CH_UA:CH_UF]}) begin
			value = 4'(character - CH_UA + HEX_TEN);
		end else begin
			is_hex = 1'b0;
		end
	end
endmodule

// ===== hdl/mactp_parse_core.sv =====
// input register, parse state and per-character state update
module mactp_parse_core (
	input  logic               clk,
	input  logic               arst_n,
	mactp_char_if.sink         chars,
	input  logic               out_free,
	output mactp_pkg::res_t    res
);
	import mactp_pkg::*;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_SEP
	} phase_t;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic [7:0] len_s1;
	logic       last_s1;

	logic [POS_W-1:0]     pos_q;
	phase_t               phase_q;
	logic [7:0]           sep_q;
	logic                 sep_form_q;
	logic [ACC_W-1:0]     acc_q;
	err_code_t            err_q;
	logic [ERR_POS_W-1:0] at_q;

	logic [POS_W-1:0]     pos_n;
	phase_t               phase_n;
	logic [7:0]           sep_n;
	logic                 sep_form_n;
	logic [ACC_W-1:0]     acc_n;
	err_code_t            err_n;
	logic [ERR_POS_W-1:0] at_n;
	logic [POS_W-1:0]     form_len;
	logic [ERR_POS_W-1:0] here;
	logic                 len_bad;
	logic                 adv;
	logic                 is_hex;
	logic [3:0]           hex_val;

	mactp_hex_decode u_hex (
		.character (char_s1),
		.is_hex    (is_hex),
		.value     (hex_val)
	);

	assign adv         = valid_s1 && (!last_s1 || out_free);
	assign chars.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.character;
			len_s1  <= chars.text_length;
			last_s1 <= chars.last_char;
		end
	end

	always_comb begin
		sep_form_n = (pos_q == '0) ? (len_s1 == SEP_LEN) : sep_form_q;
		form_len   = sep_form_n ? SEP_LEN : PLAIN_LEN;
		here       = ERR_POS_W'(pos_q + POS_W'(1));
		phase_n    = phase_q;
		sep_n      = sep_q;
		acc_n      = acc_q;
		err_n      = err_q;
		at_n       = at_q;
		if (pos_q < form_len) begin
			if (pos_q == SEP_POS) begin
				if (sep_form_n) begin
					sep_n = char_s1;
				end else if (!is_hex) begin
					err_n = ERR_LENGTH;
					at_n  = '0;
				end
			end
			if (err_n == ERR_NONE) begin
				case (phase_q)
					PH_FIRST: begin
						if (!is_hex) begin
							err_n = ERR_FIRST_DIGIT;
							at_n  = here;
						end else begin
							acc_n   = {acc_q[ACC_W-5:0], hex_val};
							phase_n = PH_SECOND;
						end
					end
					PH_SECOND: begin
						if (!is_hex) begin
							err_n = ERR_SECOND_DIGIT;
							at_n  = here;
						end else begin
							acc_n   = {acc_q[ACC_W-5:0], hex_val};
							phase_n = sep_form_n ? PH_SEP : PH_FIRST;
						end
					end
					default: begin
						if (char_s1 != sep_n) begin
							err_n = ERR_SEPARATOR;
							at_n  = here;
						end else begin
							phase_n = PH_FIRST;
						end
					end
				endcase
			end
		end
		pos_n   = (pos_q == POS_MAX) ? POS_MAX : pos_q + POS_W'(1);
		len_bad = (pos_n != len_s1) || (pos_n != form_len);

		res.valid          = adv && last_s1;
		res.error_code     = len_bad ? ERR_LENGTH : err_n;
		res.error_position = len_bad ? '0 : at_n;
		res.mac_address    = (res.error_code == ERR_NONE) ? MAC_W'(acc_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			phase_q    <= PH_FIRST;
			sep_q      <= '0;
			sep_form_q <= 1'b0;
			acc_q      <= '0;
			err_q      <= ERR_NONE;
			at_q       <= '0;
		end else if (adv) begin
			if (last_s1) begin
				pos_q      <= '0;
				phase_q    <= PH_FIRST;
				sep_q      <= '0;
				sep_form_q <= 1'b0;
				acc_q      <= '0;
				err_q      <= ERR_NONE;
				at_q       <= '0;
			end else begin
				pos_q      <= pos_n;
				phase_q    <= phase_n;
				sep_q      <= sep_n;
				sep_form_q <= sep_form_n;
				acc_q      <= acc_n;
				err_q      <= err_n;
				at_q       <= at_n;
			end
		end
	end
endmodule
